[rtl/core/ctok_pkg.sv]
// Shared types and constants of the C subset tokenizer.
package ctok_pkg;

  // Default sizes
  localparam int unsigned PREFIX_CHARS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;
  // Longest keyword
  localparam int unsigned KW_CHARS         = 7;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  // Token classes
  localparam logic [5:0] CL_ERROR      = 6'd0;
  localparam logic [5:0] CL_KW_INT     = 6'd1;
  localparam logic [5:0] CL_KW_CONST   = 6'd2;
  localparam logic [5:0] CL_KW_VOID    = 6'd3;
  localparam logic [5:0] CL_KW_CHAR    = 6'd4;
  localparam logic [5:0] CL_KW_MAIN    = 6'd5;
  localparam logic [5:0] CL_KW_IF      = 6'd6;
  localparam logic [5:0] CL_KW_ELSE    = 6'd7;
  localparam logic [5:0] CL_KW_WHILE   = 6'd8;
  localparam logic [5:0] CL_KW_SWITCH  = 6'd9;
  localparam logic [5:0] CL_KW_CASE    = 6'd10;
  localparam logic [5:0] CL_KW_DEFAULT = 6'd11;
  localparam logic [5:0] CL_KW_SCANF   = 6'd12;
  localparam logic [5:0] CL_KW_PRINTF  = 6'd13;
  localparam logic [5:0] CL_KW_RETURN  = 6'd14;
  localparam logic [5:0] CL_IDENT      = 6'd15;
  localparam logic [5:0] CL_INT        = 6'd16;
  localparam logic [5:0] CL_LE         = 6'd17;
  localparam logic [5:0] CL_LT         = 6'd18;
  localparam logic [5:0] CL_GE         = 6'd19;
  localparam logic [5:0] CL_GT         = 6'd20;
  localparam logic [5:0] CL_NE         = 6'd21;
  localparam logic [5:0] CL_EQEQ       = 6'd22;
  localparam logic [5:0] CL_ASSIGN     = 6'd23;
  localparam logic [5:0] CL_CHARLIT    = 6'd24;
  localparam logic [5:0] CL_STRING     = 6'd25;
  localparam logic [5:0] CL_PUNCT_BASE = 6'd26;

  // Characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AT     = 8'd64;
  localparam logic [7:0] CH_LBRK   = 8'd91;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'd95;
  localparam logic [7:0] CH_BTICK  = 8'd96;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Input word
  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [5:0]  token_class;
    logic [15:0] token_length;
    logic [30:0] number_value;
    logic [7:0]  char_value;
    logic        last_of_run;
  } out_word_t;

  // Classified character, front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       is_space;
    logic       is_letter;
    logic       is_digit;
    logic       is_lit;
    logic       is_punct;
    logic [3:0] punct_idx;
    logic [3:0] digit;
  } cls_word_t;

  // Back-end status
  typedef struct packed {
    logic pend_valid;
    logic mode_idle;
  } back_stat_t;

  // Lexer modes
  typedef enum logic [9:0] {
    M_IDLE   = 10'b00_0000_0001,
    M_IDENT  = 10'b00_0000_0010,
    M_NUMBER = 10'b00_0000_0100,
    M_LT     = 10'b00_0000_1000,
    M_GT     = 10'b00_0001_0000,
    M_BANG   = 10'b00_0010_0000,
    M_EQ     = 10'b00_0100_0000,
    M_QUOTE1 = 10'b00_1000_0000,
    M_QUOTE2 = 10'b01_0000_0000,
    M_STRING = 10'b10_0000_0000
  } mode_e;

endpackage

[rtl/core/ctok_front.sv]
// Front end: accepts source words and classifies each character.
module ctok_front (
  input  logic                 in_valid_i,
  input  ctok_pkg::in_word_t   in_word_i,
  output logic                 in_stall_o,
  input  logic                 q_full_i,
  output logic                 push_o,
  output ctok_pkg::cls_word_t  push_word_o
);

  function automatic ctok_pkg::cls_word_t classify(input logic [7:0] c, input logic eoi);
    ctok_pkg::cls_word_t w;
    w           = '0;
    w.ch        = c;
    w.eoi       = eoi;
    w.is_space  = (c == ctok_pkg::CH_SPACE) || (c == ctok_pkg::CH_TAB) ||
                  (c == ctok_pkg::CH_NL);
    w.is_letter = (c > ctok_pkg::CH_AT && c < ctok_pkg::CH_LBRK) ||
                  (c == ctok_pkg::CH_UNDER) ||
                  (c > ctok_pkg::CH_BTICK && c < ctok_pkg::CH_LBRACE);
    w.is_digit  = (c >= ctok_pkg::CH_ZERO) && (c <= ctok_pkg::CH_NINE);
    w.digit     = 4'(c - ctok_pkg::CH_ZERO);
    w.is_lit    = w.is_letter || w.is_digit || (c == ctok_pkg::CH_PLUS) ||
                  (c == ctok_pkg::CH_MINUS) || (c == ctok_pkg::CH_STAR) ||
                  (c == ctok_pkg::CH_SLASH);
    // punctuation index in class order
    w.is_punct  = 1'b1;
    unique case (c)
      ctok_pkg::CH_COLON:  w.punct_idx = 4'd0;
      ctok_pkg::CH_SEMI:   w.punct_idx = 4'd1;
      ctok_pkg::CH_COMMA:  w.punct_idx = 4'd2;
      ctok_pkg::CH_PLUS:   w.punct_idx = 4'd3;
      ctok_pkg::CH_MINUS:  w.punct_idx = 4'd4;
      ctok_pkg::CH_STAR:   w.punct_idx = 4'd5;
      ctok_pkg::CH_SLASH:  w.punct_idx = 4'd6;
      ctok_pkg::CH_LPAREN: w.punct_idx = 4'd7;
      ctok_pkg::CH_RPAREN: w.punct_idx = 4'd8;
      ctok_pkg::CH_LBRK:   w.punct_idx = 4'd9;
      ctok_pkg::CH_RBRK:   w.punct_idx = 4'd10;
      ctok_pkg::CH_LBRACE: w.punct_idx = 4'd11;
      ctok_pkg::CH_RBRACE: w.punct_idx = 4'd12;
      default: begin
        w.punct_idx = 4'd0;
        w.is_punct  = 1'b0;
      end
    endcase
    return w;
  endfunction

  // Handshake: take a word whenever the queue has room
  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  assign push_word_o = classify(in_word_i.in_char, in_word_i.end_of_input);

endmodule

[rtl/core/ctok_fifo.sv]
// Short register queue between front and back end.
module ctok_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           push_data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [WIDTH-1:0]           data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/ctok_back.sv]
// Back end: lexer state machine and token output stage.
module ctok_back #(
  parameter int unsigned PREFIX_CHARS = ctok_pkg::PREFIX_CHARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  ctok_pkg::cls_word_t   q_word_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ctok_pkg::out_word_t   out_word_o,
  output ctok_pkg::back_stat_t  stat_o
);

  localparam int unsigned IDX_W = $clog2(PREFIX_CHARS);
  localparam int unsigned KW_W  = 8 * ctok_pkg::KW_CHARS;

  function automatic ctok_pkg::out_word_t mk_tok(input logic [5:0] cls, input logic [15:0] len,
                                                 input logic [30:0] num, input logic [7:0] ch);
    ctok_pkg::out_word_t t;
    t.token_class  = cls;
    t.token_length = len;
    t.number_value = num;
    t.char_value   = ch;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  // Keyword lookup on the first chars, text left-aligned in w
  function automatic logic [5:0] kw_class(input logic [KW_W-1:0] w, input logic [15:0] n);
    logic [5:0] cls;
    cls = ctok_pkg::CL_IDENT;
    if      (n == 16'd3 && w[KW_W-1 -: 24] == "int")     cls = ctok_pkg::CL_KW_INT;
    else if (n == 16'd5 && w[KW_W-1 -: 40] == "const")   cls = ctok_pkg::CL_KW_CONST;
    else if (n == 16'd4 && w[KW_W-1 -: 32] == "void")    cls = ctok_pkg::CL_KW_VOID;
    else if (n == 16'd4 && w[KW_W-1 -: 32] == "char")    cls = ctok_pkg::CL_KW_CHAR;
    else if (n == 16'd4 && w[KW_W-1 -: 32] == "main")    cls = ctok_pkg::CL_KW_MAIN;
    else if (n == 16'd2 && w[KW_W-1 -: 16] == "if")      cls = ctok_pkg::CL_KW_IF;
    else if (n == 16'd4 && w[KW_W-1 -: 32] == "else")    cls = ctok_pkg::CL_KW_ELSE;
    else if (n == 16'd5 && w[KW_W-1 -: 40] == "while")   cls = ctok_pkg::CL_KW_WHILE;
    else if (n == 16'd6 && w[KW_W-1 -: 48] == "switch")  cls = ctok_pkg::CL_KW_SWITCH;
    else if (n == 16'd4 && w[KW_W-1 -: 32] == "case")    cls = ctok_pkg::CL_KW_CASE;
    else if (n == 16'd7 && w[KW_W-1 -: 56] == "default") cls = ctok_pkg::CL_KW_DEFAULT;
    else if (n == 16'd5 && w[KW_W-1 -: 40] == "scanf")   cls = ctok_pkg::CL_KW_SCANF;
    else if (n == 16'd6 && w[KW_W-1 -: 48] == "printf")  cls = ctok_pkg::CL_KW_PRINTF;
    else if (n == 16'd6 && w[KW_W-1 -: 48] == "return")  cls = ctok_pkg::CL_KW_RETURN;
    return cls;
  endfunction

  ctok_pkg::mode_e     mode_q, mode_d;
  logic [15:0]         run_q, run_d, run_inc;
  logic [30:0]         acc_q, acc_d, acc_next;
  logic [34:0]         acc_sum;
  logic [7:0]          lit_q, lit_d;
  logic [7:0]          prefix_q [PREFIX_CHARS];
  logic [KW_W-1:0]     prefix_w;
  logic                pfx_we;
  logic [IDX_W-1:0]    pfx_idx;

  ctok_pkg::out_word_t out_q, pend_q, pre_tok, b_tok, tok_a, tok_b;
  logic                out_v_q, pend_v_q;
  logic                pre_v, b_v, do_begin, tok_a_v, tok_b_v, adv;
  ctok_pkg::mode_e     b_mode;
  logic [15:0]         b_run;
  logic [30:0]         b_acc;
  logic                b_pfx;
  logic [7:0]          c;

  assign c = q_word_i.ch;

  // Keyword window over the prefix buffer
  always_comb begin
    for (int i = 0; i < ctok_pkg::KW_CHARS; i++) begin
      prefix_w[8*(ctok_pkg::KW_CHARS-1-i) +: 8] = prefix_q[i];
    end
  end

  // Saturating counters
  assign run_inc  = (run_q == ctok_pkg::LEN_MAX) ? run_q : run_q + 16'd1;
  assign acc_sum  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 35'(q_word_i.digit);
  assign acc_next = (acc_sum > 35'(ctok_pkg::NUM_MAX)) ? ctok_pkg::NUM_MAX : acc_sum[30:0];

  // Start of a new token from the current character
  always_comb begin
    b_v    = 1'b0;
    b_tok  = mk_tok(ctok_pkg::CL_ERROR, 16'd1, '0, c);
    b_mode = ctok_pkg::M_IDLE;
    b_run  = '0;
    b_acc  = 31'(q_word_i.digit);
    b_pfx  = 1'b0;
    if (q_word_i.is_space) begin
      b_mode = ctok_pkg::M_IDLE;
    end else if (q_word_i.is_letter) begin
      b_mode = ctok_pkg::M_IDENT;
      b_run  = 16'd1;
      b_pfx  = 1'b1;
    end else if (q_word_i.is_digit) begin
      b_mode = ctok_pkg::M_NUMBER;
      b_run  = 16'd1;
    end else begin
      unique case (c)
        ctok_pkg::CH_LT:     b_mode = ctok_pkg::M_LT;
        ctok_pkg::CH_GT:     b_mode = ctok_pkg::M_GT;
        ctok_pkg::CH_BANG:   b_mode = ctok_pkg::M_BANG;
        ctok_pkg::CH_EQ:     b_mode = ctok_pkg::M_EQ;
        ctok_pkg::CH_QUOTE:  b_mode = ctok_pkg::M_QUOTE1;
        ctok_pkg::CH_DQUOTE: b_mode = ctok_pkg::M_STRING;
        default: begin
          b_v = 1'b1;
          if (q_word_i.is_punct) begin
            b_tok = mk_tok(ctok_pkg::CL_PUNCT_BASE + 6'(q_word_i.punct_idx), 16'd1, '0, c);
          end
        end
      endcase
    end
  end

  // Lexer state machine
  always_comb begin
    pre_v    = 1'b0;
    pre_tok  = mk_tok(ctok_pkg::CL_ERROR, 16'd2, '0, '0);
    do_begin = 1'b0;
    mode_d   = mode_q;
    run_d    = run_q;
    acc_d    = acc_q;
    lit_d    = lit_q;
    pfx_we   = 1'b0;
    pfx_idx  = run_q[IDX_W-1:0];
    if (q_word_i.eoi) begin
      // flush whatever is pending
      mode_d = ctok_pkg::M_IDLE;
      pre_v  = 1'b1;
      unique case (mode_q)
        ctok_pkg::M_IDENT:  pre_tok = mk_tok(kw_class(prefix_w, run_q), run_q, '0, '0);
        ctok_pkg::M_NUMBER: pre_tok = mk_tok(ctok_pkg::CL_INT, run_q, acc_q, '0);
        ctok_pkg::M_LT:     pre_tok = mk_tok(ctok_pkg::CL_LT, 16'd1, '0, ctok_pkg::CH_LT);
        ctok_pkg::M_GT:     pre_tok = mk_tok(ctok_pkg::CL_GT, 16'd1, '0, ctok_pkg::CH_GT);
        ctok_pkg::M_BANG:   pre_tok = mk_tok(ctok_pkg::CL_ERROR, 16'd1, '0, ctok_pkg::CH_BANG);
        ctok_pkg::M_EQ:     pre_tok = mk_tok(ctok_pkg::CL_ASSIGN, 16'd1, '0, ctok_pkg::CH_EQ);
        ctok_pkg::M_QUOTE1: pre_tok = mk_tok(ctok_pkg::CL_ERROR, 16'd1, '0, '0);
        ctok_pkg::M_QUOTE2: pre_tok = mk_tok(ctok_pkg::CL_ERROR, 16'd2, '0, '0);
        ctok_pkg::M_STRING: pre_tok = mk_tok(ctok_pkg::CL_ERROR, run_q, '0, '0);
        default:            pre_v   = 1'b0;
      endcase
    end else begin
      unique case (mode_q)
        ctok_pkg::M_IDENT: begin
          if (q_word_i.is_letter || q_word_i.is_digit) begin
            pfx_we = (run_q < 16'(PREFIX_CHARS));
            run_d  = run_inc;
          end else begin
            pre_v    = 1'b1;
            pre_tok  = mk_tok(kw_class(prefix_w, run_q), run_q, '0, '0);
            do_begin = 1'b1;
          end
        end
        ctok_pkg::M_NUMBER: begin
          if (q_word_i.is_digit) begin
            acc_d = acc_next;
            run_d = run_inc;
          end else begin
            pre_v    = 1'b1;
            pre_tok  = mk_tok(ctok_pkg::CL_INT, run_q, acc_q, '0);
            do_begin = 1'b1;
          end
        end
        ctok_pkg::M_LT, ctok_pkg::M_GT, ctok_pkg::M_BANG, ctok_pkg::M_EQ: begin
          pre_v = 1'b1;
          if (c == ctok_pkg::CH_EQ) begin
            mode_d = ctok_pkg::M_IDLE;
            if (mode_q == ctok_pkg::M_LT) begin
              pre_tok = mk_tok(ctok_pkg::CL_LE, 16'd2, '0, '0);
            end else if (mode_q == ctok_pkg::M_GT) begin
              pre_tok = mk_tok(ctok_pkg::CL_GE, 16'd2, '0, '0);
            end else if (mode_q == ctok_pkg::M_BANG) begin
              pre_tok = mk_tok(ctok_pkg::CL_NE, 16'd2, '0, '0);
            end else begin
              pre_tok = mk_tok(ctok_pkg::CL_EQEQ, 16'd2, '0, '0);
            end
          end else begin
            do_begin = 1'b1;
            if (mode_q == ctok_pkg::M_LT) begin
              pre_tok = mk_tok(ctok_pkg::CL_LT, 16'd1, '0, ctok_pkg::CH_LT);
            end else if (mode_q == ctok_pkg::M_GT) begin
              pre_tok = mk_tok(ctok_pkg::CL_GT, 16'd1, '0, ctok_pkg::CH_GT);
            end else if (mode_q == ctok_pkg::M_BANG) begin
              pre_tok = mk_tok(ctok_pkg::CL_ERROR, 16'd1, '0, ctok_pkg::CH_BANG);
            end else begin
              pre_tok = mk_tok(ctok_pkg::CL_ASSIGN, 16'd1, '0, ctok_pkg::CH_EQ);
            end
          end
        end
        ctok_pkg::M_QUOTE1: begin
          if (q_word_i.is_lit) begin
            lit_d  = c;
            mode_d = ctok_pkg::M_QUOTE2;
          end else begin
            pre_v  = 1'b1;
            mode_d = ctok_pkg::M_IDLE;
          end
        end
        ctok_pkg::M_QUOTE2: begin
          pre_v = 1'b1;
          if (c == ctok_pkg::CH_QUOTE) begin
            pre_tok = mk_tok(ctok_pkg::CL_CHARLIT, 16'd3, '0, lit_q);
            mode_d  = ctok_pkg::M_IDLE;
          end else begin
            do_begin = 1'b1;
          end
        end
        ctok_pkg::M_STRING: begin
          if (c == ctok_pkg::CH_DQUOTE) begin
            pre_v   = 1'b1;
            pre_tok = mk_tok(ctok_pkg::CL_STRING, run_q, '0, '0);
            mode_d  = ctok_pkg::M_IDLE;
          end else begin
            run_d = run_inc;
          end
        end
        ctok_pkg::M_IDLE: do_begin = 1'b1;
        default:          mode_d   = ctok_pkg::M_IDLE;
      endcase
    end
    // the character is lexed afresh
    if (do_begin) begin
      mode_d = b_mode;
      run_d  = b_run;
      acc_d  = b_acc;
      if (b_pfx) begin
        pfx_we  = 1'b1;
        pfx_idx = '0;
      end
    end
  end

  // Order the up to two tokens of this word
  always_comb begin
    tok_b_v = pre_v && do_begin && b_v;
    tok_a_v = pre_v || (do_begin && b_v);
    tok_a   = pre_v ? pre_tok : b_tok;
    tok_b   = b_tok;
    tok_a.last_of_run = !tok_b_v;
    tok_b.last_of_run = 1'b1;
  end

  // Pop when the output register can take this word's tokens
  assign adv     = !out_v_q || !out_stall_i;
  assign q_pop_o = q_valid_i && !pend_v_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ctok_pkg::M_IDLE;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        mode_q <= mode_d;
      end
      if (adv) begin
        if (pend_v_q) begin
          out_v_q  <= 1'b1;
          pend_v_q <= 1'b0;
        end else if (q_pop_o && tok_a_v) begin
          out_v_q  <= 1'b1;
          pend_v_q <= tok_b_v;
        end else begin
          out_v_q  <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      run_q <= run_d;
      acc_q <= acc_d;
      lit_q <= lit_d;
      if (pfx_we) begin
        prefix_q[pfx_idx] <= c;
      end
    end
    if (adv) begin
      if (pend_v_q) begin
        out_q <= pend_q;
      end else if (q_pop_o && tok_a_v) begin
        out_q  <= tok_a;
        pend_q <= tok_b;
      end
    end
  end

  assign out_valid_o       = out_v_q;
  assign out_word_o        = out_q;
  assign stat_o.pend_valid = pend_v_q;
  assign stat_o.mode_idle  = (mode_q == ctok_pkg::M_IDLE);

endmodule

[rtl/core/c_subset_tokenizer.sv]
// Top level of the streaming C subset tokenizer.
//
// Input channel: one source byte per word (in_char) plus an end_of_input
// flag; a word moves when in_valid_i is high and in_stall_o is low.
// Output channel: one token per word (class, length, integer value,
// character, last_of_run); a word moves when out_valid_o is high and
// out_stall_i is low. A character yields zero, one or two tokens.
// Throughput: one character per cycle while the output register can
// advance; a character that closes one token and emits another holds
// back the next character until its second token has moved into the
// output register. A token caused by a character passes the front queue
// register and then the lexer output register.
// Reset clears the lexer to idle and empties the queue and output stage.
// While the receiver stalls, the output word holds; the lexer stops and
// the front queue (QUEUE_DEPTH words) fills before in_stall_o rises.
module c_subset_tokenizer #(
  parameter int unsigned PREFIX_CHARS = ctok_pkg::PREFIX_CHARS_DEF,
  parameter int unsigned QUEUE_DEPTH  = ctok_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ctok_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ctok_pkg::out_word_t out_word_o
);

  localparam int unsigned CW    = $bits(ctok_pkg::cls_word_t);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                 q_full, q_push, q_pop, q_valid;
  ctok_pkg::cls_word_t  push_word, q_word;
  logic [CW-1:0]        q_data;
  logic [CNT_W-1:0]     q_count;
  ctok_pkg::back_stat_t stat;

  ctok_front u_front (
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_word_o (push_word)
  );

  ctok_fifo #(
    .WIDTH (CW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  assign q_word = ctok_pkg::cls_word_t'(q_data);

  ctok_back #(
    .PREFIX_CHARS (PREFIX_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_word_i    (q_word),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .stat_o      (stat)
  );

`ifndef SYNTHESIS
  // A second token waits only behind a shown first token
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pend_valid |-> out_valid_o)
    else $error("pending token without output token");

  // A token not last of its run always has its partner queued
  a_not_last_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.last_of_run) |-> stat.pend_valid)
    else $error("first of two tokens without its partner");

  // End of input always returns the lexer to idle
  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_word.eoi) |=> stat.mode_idle)
    else $error("lexer not idle after end of input");

  // Queue occupancy bound
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

[tb/sv/ctok_token_checker.sv]
// Token checker for the C subset tokenizer: predicts tokens per source byte and compares.
module ctok_token_checker
  import ctok_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          tokens_o,
  output int          chars_o,
  output logic [63:0] classes_o
);

  localparam int unsigned PFX = PREFIX_CHARS_DEF;

  // Lexer state as the predictor sees it
  mode_e       mode;
  logic [7:0]  name_buf [PFX];
  logic [15:0] run_len;
  logic [30:0] num_acc;
  logic [7:0]  lit_char;

  // Tokens of the current byte, then all tokens still owed by the block
  out_word_t   step_toks [$];
  out_word_t   tokens_due [$];

  int          bad_count;
  int          tokens_seen;
  int          chars_taken;
  logic [63:0] class_hits;

  function automatic logic is_letter(logic [7:0] c);
    return (c > CH_AT && c < CH_LBRK) || c == CH_UNDER || (c > CH_BTICK && c < CH_LBRACE);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == LEN_MAX) ? v : v + 16'd1;
  endfunction

  // Punctuation class, or error for a byte that starts nothing
  function automatic logic [5:0] punct_class(logic [7:0] c);
    case (c)
      CH_COLON:  return CL_PUNCT_BASE;
      CH_SEMI:   return CL_PUNCT_BASE + 6'd1;
      CH_COMMA:  return CL_PUNCT_BASE + 6'd2;
      CH_PLUS:   return CL_PUNCT_BASE + 6'd3;
      CH_MINUS:  return CL_PUNCT_BASE + 6'd4;
      CH_STAR:   return CL_PUNCT_BASE + 6'd5;
      CH_SLASH:  return CL_PUNCT_BASE + 6'd6;
      CH_LPAREN: return CL_PUNCT_BASE + 6'd7;
      CH_RPAREN: return CL_PUNCT_BASE + 6'd8;
      CH_LBRK:   return CL_PUNCT_BASE + 6'd9;
      CH_RBRK:   return CL_PUNCT_BASE + 6'd10;
      CH_LBRACE: return CL_PUNCT_BASE + 6'd11;
      CH_RBRACE: return CL_PUNCT_BASE + 6'd12;
      default:   return CL_ERROR;
    endcase
  endfunction

  // Keyword lookup on the kept prefix; longer names are plain identifiers
  function automatic logic [5:0] name_class();
    logic [8*PFX-1:0] key;
    key = '0;
    if (run_len > PFX) return CL_IDENT;
    for (int i = 0; i < PFX; i++) begin
      if (i < run_len) key = {key[8*PFX-9:0], name_buf[i]};
    end
    case (key)
      "int":     return CL_KW_INT;
      "const":   return CL_KW_CONST;
      "void":    return CL_KW_VOID;
      "char":    return CL_KW_CHAR;
      "main":    return CL_KW_MAIN;
      "if":      return CL_KW_IF;
      "else":    return CL_KW_ELSE;
      "while":   return CL_KW_WHILE;
      "switch":  return CL_KW_SWITCH;
      "case":    return CL_KW_CASE;
      "default": return CL_KW_DEFAULT;
      "scanf":   return CL_KW_SCANF;
      "printf":  return CL_KW_PRINTF;
      "return":  return CL_KW_RETURN;
      default:   return CL_IDENT;
    endcase
  endfunction

  function automatic void add_token(logic [5:0] cls, logic [15:0] len, logic [30:0] num,
                                    logic [7:0] ch);
    out_word_t t;
    t.token_class  = cls;
    t.token_length = len;
    t.number_value = num;
    t.char_value   = ch;
    t.last_of_run  = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void clear_run();
    mode     = M_IDLE;
    run_len  = '0;
    num_acc  = '0;
    lit_char = '0;
  endfunction

  // One-character operator left pending when no '=' follows
  function automatic void single_op_token();
    case (mode)
      M_LT:    add_token(CL_LT, 1, 0, CH_LT);
      M_GT:    add_token(CL_GT, 1, 0, CH_GT);
      M_BANG:  add_token(CL_ERROR, 1, 0, CH_BANG);
      default: add_token(CL_ASSIGN, 1, 0, CH_EQ);
    endcase
  endfunction

  // Byte seen with nothing pending
  function automatic void lex_fresh(logic [7:0] c);
    clear_run();
    if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
      // whitespace only separates
    end else if (is_letter(c)) begin
      foreach (name_buf[i]) name_buf[i] = '0;
      name_buf[0] = c;
      run_len     = 16'd1;
      mode        = M_IDENT;
    end else if (is_digit(c)) begin
      num_acc = c - CH_ZERO;
      run_len = 16'd1;
      mode    = M_NUMBER;
    end else begin
      case (c)
        CH_LT:     mode = M_LT;
        CH_GT:     mode = M_GT;
        CH_BANG:   mode = M_BANG;
        CH_EQ:     mode = M_EQ;
        CH_QUOTE:  mode = M_QUOTE1;
        CH_DQUOTE: mode = M_STRING;
        default:   add_token(punct_class(c), 1, 0, c);
      endcase
    end
  endfunction

  // Predict the tokens caused by one accepted input word
  function automatic void lex_word(in_word_t w);
    logic [7:0]  c;
    logic [5:0]  cls;
    logic [35:0] wide;
    c = w.in_char;
    step_toks.delete();
    if (w.end_of_input) begin
      case (mode)
        M_IDENT:                   add_token(name_class(), run_len, 0, 0);
        M_NUMBER:                  add_token(CL_INT, run_len, num_acc, 0);
        M_LT, M_GT, M_BANG, M_EQ:  single_op_token();
        M_QUOTE1:                  add_token(CL_ERROR, 1, 0, 0);
        M_QUOTE2:                  add_token(CL_ERROR, 2, 0, 0);
        M_STRING:                  add_token(CL_ERROR, run_len, 0, 0);
        default: ;
      endcase
      clear_run();
    end else begin
      case (mode)
        M_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            if (run_len < PFX) name_buf[run_len] = c;
            run_len = bump(run_len);
          end else begin
            add_token(name_class(), run_len, 0, 0);
            lex_fresh(c);
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            wide    = {5'd0, num_acc} * 36'd10 + (c - CH_ZERO);
            num_acc = (wide > NUM_MAX) ? NUM_MAX : wide[30:0];
            run_len = bump(run_len);
          end else begin
            add_token(CL_INT, run_len, num_acc, 0);
            lex_fresh(c);
          end
        end
        M_LT, M_GT, M_BANG, M_EQ: begin
          if (c == CH_EQ) begin
            case (mode)
              M_LT:    cls = CL_LE;
              M_GT:    cls = CL_GE;
              M_BANG:  cls = CL_NE;
              default: cls = CL_EQEQ;
            endcase
            add_token(cls, 2, 0, 0);
            clear_run();
          end else begin
            single_op_token();
            lex_fresh(c);
          end
        end
        M_QUOTE1: begin
          if (is_letter(c) || is_digit(c) || c == CH_PLUS || c == CH_MINUS
              || c == CH_STAR || c == CH_SLASH) begin
            lit_char = c;
            mode     = M_QUOTE2;
          end else begin
            add_token(CL_ERROR, 2, 0, 0);
            clear_run();
          end
        end
        M_QUOTE2: begin
          if (c == CH_QUOTE) begin
            add_token(CL_CHARLIT, 3, 0, lit_char);
            clear_run();
          end else begin
            add_token(CL_ERROR, 2, 0, 0);
            lex_fresh(c);
          end
        end
        M_STRING: begin
          if (c == CH_DQUOTE) begin
            add_token(CL_STRING, run_len, 0, 0);
            clear_run();
          end else begin
            run_len = bump(run_len);
          end
        end
        default: lex_fresh(c);
      endcase
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_of_run = 1'b1;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endfunction

  // Compare one delivered token with the oldest one owed
  function automatic void check_token(out_word_t got);
    out_word_t want;
    tokens_seen++;
    class_hits[got.token_class] = 1'b1;
    if (tokens_due.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("token %0d unexpected: class %0d len %0d num %0d char %0d last %0b",
                 tokens_seen, got.token_class, got.token_length, got.number_value,
                 got.char_value, got.last_of_run);
    end else begin
      want = tokens_due.pop_front();
      if (got.token_class !== want.token_class || got.token_length !== want.token_length
          || got.number_value !== want.number_value || got.char_value !== want.char_value
          || got.last_of_run !== want.last_of_run) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("token %0d mismatch: expected class %0d len %0d num %0d char %0d last %0b",
                   tokens_seen, want.token_class, want.token_length, want.number_value,
                   want.char_value, want.last_of_run);
          $display("  got class %0d len %0d num %0d char %0d last %0b",
                   got.token_class, got.token_length, got.number_value, got.char_value,
                   got.last_of_run);
        end
      end
    end
  endfunction

  // Output words are compared before the new input word is predicted:
  // a token never leaves in the cycle its byte is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (name_buf[i]) name_buf[i] = '0;
      clear_run();
      tokens_due.delete();
      bad_count   = 0;
      tokens_seen = 0;
      chars_taken = 0;
      class_hits  = '0;
    end else begin
      if (out_valid_i && !out_stall_i) check_token(out_word_i);
      if (in_valid_i && !in_stall_i) begin
        lex_word(in_word_i);
        chars_taken++;
      end
    end
    mismatches_o <= bad_count;
    pending_o    <= tokens_due.size();
    tokens_o     <= tokens_seen;
    chars_o      <= chars_taken;
    classes_o    <= class_hits;
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the C subset tokenizer: source byte stimulus and verdict.
module tb;
  import ctok_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1800;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;

  logic        steady    = 1'b0;
  int          quiet     = 0;
  int          sent      = 0;
  string       keywords [14];

  int          mismatches;
  int          pending;
  int          tokens;
  int          chars;
  logic [63:0] classes;

  c_subset_tokenizer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  ctok_token_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .tokens_o     (tokens),
    .chars_o      (chars),
    .classes_o    (classes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stalls at random, except during the steady stretch
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 12);
  end

  // Cycles without any word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("c_subset_tokenizer regression: fail");
    $finish;
  end

  // Offer one word, with random gaps ahead of it, and hold it until taken
  task automatic send_word(in_word_t w);
    if (!steady) begin
      while ($urandom_range(99) < 12) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    in_word_t w;
    w.in_char      = c;
    w.end_of_input = 1'b0;
    send_word(w);
  endtask

  task automatic send_eoi();
    in_word_t w;
    w.in_char      = $urandom_range(255);
    w.end_of_input = 1'b1;
    send_word(w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] any_letter();
    int k;
    k = $urandom_range(52);
    if (k < 26) return "A" + k;
    if (k < 52) return "a" + k - 26;
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] any_but_dquote();
    logic [7:0] c;
    c = $urandom_range(255);
    return (c == CH_DQUOTE) ? CH_SPACE : c;
  endfunction

  initial begin
    int         n;
    int         pick;
    int         start;
    string      punct;
    string      ws;
    punct    = ":;,+-*/()[]{}";
    ws       = " \t\n";
    keywords = '{"int", "const", "void", "char", "main", "if", "else", "while",
                 "switch", "case", "default", "scanf", "printf", "return"};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes, lone bang, broken literals, operators, flushes
    send_char(8'h00);
    send_char(8'hFF);
    send_text("!a");
    send_char(CH_QUOTE);
    send_char(CH_TAB);
    send_text("'9;");
    send_text("'z'");
    send_text("<=!");
    send_eoi();
    send_text("=\"");
    send_eoi();
    send_eoi();
    // String of arbitrary bytes
    send_char(CH_DQUOTE);
    repeat (20) send_char(any_but_dquote());
    send_char(CH_DQUOTE);

    // Random: mostly well-formed tokens with random content, some noise
    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      steady <= (sent - start > 600) && (sent - start < 1000);
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_char($urandom_range(255));
      end else if (pick < 13) begin
        send_eoi();
      end else if (pick < 25) begin
        send_text(keywords[$urandom_range(13)]);
      end else if (pick < 40) begin
        // identifiers, a few longer than the kept prefix
        n = ($urandom_range(8) == 0) ? $urandom_range(14, 9) : $urandom_range(6, 1);
        send_char(any_letter());
        repeat (n - 1) send_char(($urandom_range(3) == 0) ? "0" + $urandom_range(9)
                                                          : any_letter());
      end else if (pick < 52) begin
        // numbers, some past the saturation point
        n = ($urandom_range(3) == 0) ? $urandom_range(12, 9) : $urandom_range(4, 1);
        repeat (n) send_char("0" + $urandom_range(9));
      end else if (pick < 64) begin
        case ($urandom_range(7))
          0: send_text("<=");
          1: send_text("<");
          2: send_text(">=");
          3: send_text(">");
          4: send_text("!=");
          5: send_text("!");
          6: send_text("==");
          default: send_text("=");
        endcase
      end else if (pick < 72) begin
        // character literals, sometimes broken
        send_char(CH_QUOTE);
        if ($urandom_range(7) == 0) send_char($urandom_range(255));
        else send_char(($urandom_range(4) == 0) ? punct[$urandom_range(6, 3)] : any_letter());
        if ($urandom_range(7) == 0) send_char($urandom_range(255));
        else send_char(CH_QUOTE);
      end else if (pick < 80) begin
        // strings, sometimes left open at end of input
        send_char(CH_DQUOTE);
        repeat ($urandom_range(8)) send_char(any_but_dquote());
        if ($urandom_range(5) == 0) send_eoi();
        else send_char(CH_DQUOTE);
      end else begin
        send_char(punct[$urandom_range(12)]);
      end
      if ($urandom_range(1) == 1) send_char(ws[$urandom_range(2)]);
    end
    send_eoi();
    in_valid <= 1'b0;
    steady   <= 1'b0;

    // Drain, then wait for stray words
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d source bytes (directed edge cases, random tokens), %0d tokens checked",
             chars, tokens);
    $display("%0d token classes seen, %0d mismatches", $countones(classes), mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("c_subset_tokenizer regression: pass");
    end else begin
      $display("c_subset_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
